// File: rtl/ntaf_pkg.sv
// Package of the number-to-ASCII formatter: command codes, item and cell types,
// character constants and the hex digit lookup. No dependencies.
`default_nettype none

package ntaf_pkg;

  localparam int NUM_CELLS  = 32;
  localparam int NUM_DIGITS = 10;
  localparam int NUM_CHARS  = 11;
  localparam int LAST_POS   = NUM_CHARS - 1;

  localparam logic [7:0]   ASCII_ZERO  = 8'h30;
  localparam logic [7:0]   ASCII_MINUS = 8'h2d;
  localparam logic [127:0] HEX_CHARS   = "0123456789abcdef";

  typedef enum logic [2:0] {
    CMD_RAW   = 3'd0,
    CMD_HEX8  = 3'd1,
    CMD_HEX16 = 3'd2,
    CMD_HEX32 = 3'd3,
    CMD_DEC   = 3'd4
  } cmd_t;

  typedef logic [3:0] pos_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic                    vld;
    cmd_t                    cmd;
    logic                    neg;
    logic [31:0]             mag;
    logic [4*NUM_DIGITS-1:0] bcd;
  } cell_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return HEX_CHARS[{~nib, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/ntaf_cell.sv
// One conversion cell: a single shift-and-add-3 step from binary to BCD.
// Depends on ntaf_pkg for the cell type.
`default_nettype none

module ntaf_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire ntaf_pkg::cell_t prev,
  output ntaf_pkg::cell_t    cur
);

  logic            vld_r;
  ntaf_pkg::cell_t data_r;
  ntaf_pkg::cell_t data_nxt;
  logic [4*ntaf_pkg::NUM_DIGITS-1:0] adj;

  // The magnitude rotates, so after all cells it is back to its original value.
  always_comb begin
    for (int d = 0; d < ntaf_pkg::NUM_DIGITS; d++) begin
      adj[4*d +: 4] = (prev.bcd[4*d +: 4] >= 4'd5) ? (prev.bcd[4*d +: 4] + 4'd3)
                                                   : prev.bcd[4*d +: 4];
    end
    data_nxt     = prev;
    data_nxt.mag = {prev.mag[30:0], prev.mag[31]};
    data_nxt.bcd = {adj[4*ntaf_pkg::NUM_DIGITS-2:0], prev.mag[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    cur     = data_r;
    cur.vld = vld_r;
  end

endmodule

`default_nettype wire

// File: rtl/ntaf_serializer.sv
// Buffer that lays out one converted item; sends one character a cycle unless stalled.
// Depends on ntaf_pkg for types, constants and the hex lookup.
`default_nettype none

module ntaf_serializer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ntaf_pkg::cell_t src,
  output logic                 load,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output ntaf_pkg::out_item_t  out_item
);

  logic                  busy_r;
  logic                  busy_nxt;
  ntaf_pkg::pos_t        ptr_r;
  ntaf_pkg::pos_t        ptr_nxt;
  ntaf_pkg::pos_t        skip_r;
  ntaf_pkg::pos_t        skip_nxt;
  logic [7:0]            chars_r   [ntaf_pkg::NUM_CHARS];
  logic [7:0]            chars_ld  [ntaf_pkg::NUM_CHARS];
  ntaf_pkg::pos_t        start_ld;
  ntaf_pkg::pos_t        first_nz;
  logic                  is_last;
  logic                  out_fire;

  assign is_last  = (ptr_r == ntaf_pkg::pos_t'(ntaf_pkg::LAST_POS));
  assign out_fire = busy_r && !out_stall;
  assign load     = src.vld && (!busy_r || (out_fire && is_last));

  assign out_valid         = busy_r;
  assign out_item.char_out = chars_r[ptr_r];
  assign out_item.last     = is_last;

  always_comb begin
    first_nz = ntaf_pkg::pos_t'(ntaf_pkg::LAST_POS);
    for (int j = ntaf_pkg::NUM_DIGITS - 1; j >= 0; j--) begin
      if (src.bcd[4*(ntaf_pkg::NUM_DIGITS-1-j) +: 4] != 4'd0) begin
        first_nz = ntaf_pkg::pos_t'(j + 1);
      end
    end
    for (int k = 0; k < ntaf_pkg::NUM_CHARS; k++) begin
      chars_ld[k] = ntaf_pkg::ASCII_ZERO;
    end
    start_ld = ntaf_pkg::pos_t'(ntaf_pkg::LAST_POS);
    case (src.cmd)
      ntaf_pkg::CMD_RAW: begin
        chars_ld[ntaf_pkg::LAST_POS] = src.mag[7:0];
      end
      ntaf_pkg::CMD_HEX8, ntaf_pkg::CMD_HEX16, ntaf_pkg::CMD_HEX32: begin
        for (int k = 0; k < 8; k++) begin
          chars_ld[ntaf_pkg::LAST_POS-k] = ntaf_pkg::hex_char(src.mag[4*k +: 4]);
        end
        if (src.cmd == ntaf_pkg::CMD_HEX8) begin
          start_ld = ntaf_pkg::pos_t'(ntaf_pkg::LAST_POS - 1);
        end else if (src.cmd == ntaf_pkg::CMD_HEX16) begin
          start_ld = ntaf_pkg::pos_t'(ntaf_pkg::LAST_POS - 3);
        end else begin
          start_ld = ntaf_pkg::pos_t'(ntaf_pkg::LAST_POS - 7);
        end
      end
      ntaf_pkg::CMD_DEC: begin
        chars_ld[0] = ntaf_pkg::ASCII_MINUS;
        for (int j = 0; j < ntaf_pkg::NUM_DIGITS; j++) begin
          chars_ld[j+1] = ntaf_pkg::ASCII_ZERO
                        + {4'd0, src.bcd[4*(ntaf_pkg::NUM_DIGITS-1-j) +: 4]};
        end
        start_ld = src.neg ? ntaf_pkg::pos_t'(0) : first_nz;
      end
      default: begin
        start_ld = ntaf_pkg::pos_t'(ntaf_pkg::LAST_POS);
      end
    endcase
  end

  // After the minus sign the pointer jumps over the suppressed leading zeros.
  always_comb begin
    busy_nxt = busy_r;
    ptr_nxt  = ptr_r;
    skip_nxt = skip_r;
    if (load) begin
      busy_nxt = 1'b1;
      ptr_nxt  = start_ld;
      skip_nxt = first_nz;
    end else if (out_fire) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else if (ptr_r == ntaf_pkg::pos_t'(0)) begin
        ptr_nxt = skip_r;
      end else begin
        ptr_nxt = ptr_r + ntaf_pkg::pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    skip_r <= skip_nxt;
    if (load) begin
      chars_r <= chars_ld;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_fire && is_last && !src.vld) |=> !busy_r)
    else $error("buffer stayed busy after its last character");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (ptr_r <= ntaf_pkg::pos_t'(ntaf_pkg::LAST_POS)))
    else $error("character pointer out of range");

  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ptr_r == ntaf_pkg::pos_t'(0)) |-> (chars_r[0] == ntaf_pkg::ASCII_MINUS))
    else $error("position zero sent without a minus sign");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_fire) |=> (busy_r && $stable(ptr_r)))
    else $error("stalled character changed");

endmodule

`default_nettype wire

// File: rtl/number_to_ascii_formatter_unit.sv
// Top level of the number-to-ASCII formatter: enable register, input decode, a chain
// of conversion cells and the character serializer. Depends on ntaf_pkg, ntaf_cell
// and ntaf_serializer.
//
// Use: an item (cmd, value) is accepted when in_valid is high and in_stall low.
// Commands print a raw byte, 2, 4 or 8 lowercase hex digits, or signed decimal
// with a leading minus and no leading zeros. Each character leaves on the out_
// channel as one item, with last set on the final character of its request.
// Unknown commands, and every request while enable is 0, are accepted and print
// nothing. The enable register is written over cfg_ with cfg_ready always high.
// An accepted item passes through each cell of the 32-cell binary-to-BCD chain
// and then loads into the serializer. Throughput: one character per cycle while
// out_stall is low, so a request sends 1 to 11 characters (raw 1, hex 2/4/8,
// decimal 1 to 11); the chain takes a new item every cycle while it moves.
// When out_stall is high the current character holds; once a converted item
// waits at the chain's end, the chain freezes and in_stall rises.
// Reset clears all valid state and sets enable to 1.
`default_nettype none

module number_to_ascii_formatter_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ntaf_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ntaf_pkg::out_item_t       out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data
);

  logic            enable_r;
  logic            adv;
  logic            load;
  logic            in_fire;
  logic            cmd_ok;
  ntaf_pkg::cell_t head;
  ntaf_pkg::cell_t links [ntaf_pkg::NUM_CELLS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable_r <= cfg_data;
    end
  end

  assign adv      = !links[ntaf_pkg::NUM_CELLS].vld || load;
  assign in_stall = !adv;
  assign in_fire  = in_valid && adv;

  always_comb begin
    unique case (ntaf_pkg::cmd_t'(in_item.cmd)) inside
      ntaf_pkg::CMD_RAW, ntaf_pkg::CMD_HEX8, ntaf_pkg::CMD_HEX16,
      ntaf_pkg::CMD_HEX32, ntaf_pkg::CMD_DEC: cmd_ok = 1'b1;
      default:                                 cmd_ok = 1'b0;
    endcase
    head      = '0;
    head.vld  = in_fire && enable_r && cmd_ok;
    head.cmd  = ntaf_pkg::cmd_t'(in_item.cmd);
    head.neg  = (head.cmd == ntaf_pkg::CMD_DEC) && in_item.value[31];
    head.mag  = head.neg ? (~in_item.value + 32'd1) : in_item.value;
  end

  assign links[0] = head;

  for (genvar i = 0; i < ntaf_pkg::NUM_CELLS; i++) begin : g_cells
    ntaf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .prev  (links[i]),
      .cur   (links[i+1])
    );
  end

  ntaf_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .src       (links[ntaf_pkg::NUM_CELLS]),
    .load      (load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  a_stall_means_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (links[ntaf_pkg::NUM_CELLS].vld && out_valid))
    else $error("input stalled with nothing waiting at the chain end");

  a_disabled_drops: assert property (@(posedge clk) disable iff (!rst_n)
    !enable_r |-> !head.vld)
    else $error("item entered the chain while output is disabled");

  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(links[ntaf_pkg::NUM_CELLS]))
    else $error("chain end changed while frozen");

endmodule

`default_nettype wire
